/* hdl/sbsp_pkg.sv */
// ---------------------------------------------------------------------------
// sbsp_pkg: shared types and symbol tables of the six-bit symbol packer
// Alphabet lookups in both directions, transaction and result types.
// ---------------------------------------------------------------------------
package sbsp_pkg;

   // number of symbols in the alphabet
   localparam int unsigned SYMBOL_COUNT = 57;

   // mode codes carried in req_tuser
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // position within the 4-symbol / 3-byte group
   typedef enum logic [1:0] {
      PH_0 = 2'd0,
      PH_1 = 2'd1,
      PH_2 = 2'd2,
      PH_3 = 2'd3
   } phase_type;

   // one input transaction
   typedef struct packed {
      logic       mode;
      logic [7:0] data;
      logic       last;
   } item_type;

   // one result transaction
   typedef struct packed {
      logic [7:0] value;
      logic       error;
      logic       final_res;
   } result_type;

   // results produced by one item, entry 0 goes out first
   typedef struct packed {
      logic [1:0]             cnt;
      result_type [1:0]       res;
   } core_out_type;

   // character to {found, index}; lowercase letters fold to uppercase
   function automatic logic [6:0] char_to_index(input logic [7:0] c);
      logic [7:0] u;
      logic [7:0] t;
      logic       found;
      logic [5:0] idx;
      u     = c;
      t     = 8'd0;
      found = 1'b1;
      idx   = 6'd0;
      if (c >= 8'h61 && c <= 8'h7A) begin
         u = c - 8'd32;
      end
      case (u) inside
         8'h00:         idx = 6'd0;
         [8'h30:8'h39]: begin
            t   = u - 8'd47;
            idx = t[5:0];
         end
         [8'h41:8'h5A]: begin
            t   = u - 8'd54;
            idx = t[5:0];
         end
         8'h2C: idx = 6'd37; // ,
         8'h2E: idx = 6'd38; // .
         8'h21: idx = 6'd39; // !
         8'h23: idx = 6'd40; // #
         8'h24: idx = 6'd41; // $
         8'h28: idx = 6'd42; // (
         8'h29: idx = 6'd43; // )
         8'h2B: idx = 6'd44; // +
         8'h2D: idx = 6'd45; // -
         8'h3D: idx = 6'd46; // =
         8'h3F: idx = 6'd47; // ?
         8'h3A: idx = 6'd48; // :
         8'h3B: idx = 6'd49; // ;
         8'h2F: idx = 6'd50; // /
         8'h5C: idx = 6'd51; // backslash
         8'h26: idx = 6'd52; // &
         8'h22: idx = 6'd53; // double quote
         8'h27: idx = 6'd54; // single quote
         8'h20: idx = 6'd55; // space
         8'h0A: idx = 6'd56; // newline
         default: found = 1'b0;
      endcase
      // symbols past the active alphabet size are not found
      if ({1'b0, idx} >= 7'(SYMBOL_COUNT)) begin
         found = 1'b0;
      end
      return {found, idx};
   endfunction

   // index to {ok, character}; an index past the alphabet gives 0, not ok
   function automatic logic [8:0] index_to_char(input logic [5:0] idx);
      logic [7:0] ch;
      logic       ok;
      ch = 8'h00;
      ok = ({1'b0, idx} < 7'(SYMBOL_COUNT));
      case (idx) inside
         6'd0:          ch = 8'h00;
         [6'd1:6'd10]:  ch = {2'b00, idx} + 8'd47;
         [6'd11:6'd36]: ch = {2'b00, idx} + 8'd54;
         6'd37: ch = 8'h2C;
         6'd38: ch = 8'h2E;
         6'd39: ch = 8'h21;
         6'd40: ch = 8'h23;
         6'd41: ch = 8'h24;
         6'd42: ch = 8'h28;
         6'd43: ch = 8'h29;
         6'd44: ch = 8'h2B;
         6'd45: ch = 8'h2D;
         6'd46: ch = 8'h3D;
         6'd47: ch = 8'h3F;
         6'd48: ch = 8'h3A;
         6'd49: ch = 8'h3B;
         6'd50: ch = 8'h2F;
         6'd51: ch = 8'h5C;
         6'd52: ch = 8'h26;
         6'd53: ch = 8'h22;
         6'd54: ch = 8'h27;
         6'd55: ch = 8'h20;
         6'd56: ch = 8'h0A;
         default: ch = 8'h00;
      endcase
      if (!ok) begin
         ch = 8'h00;
      end
      return {ok, ch};
   endfunction

endpackage

/* hdl/six_bit_symbol_packer_top.sv */
// ---------------------------------------------------------------------------
// six_bit_symbol_packer_top: six-bit alphabet codec, stream in / stream out
// Input register, combinational pack/unpack core and a four-entry result
// queue that lets new items in while earlier results wait.
// ---------------------------------------------------------------------------
//  channel | dir | tdata           | tuser  | tlast
//  req_    | in  | [7:0] data      | mode   | last
//  rsp_    | out | [7:0] value     | error  | final_res
//
//  One item enters per cycle while req_tready is high; it waits in the
//  input register until the queue has room for two results. Output is
//  one result per cycle while rsp_tready is high, so items giving two
//  results hold the sustained input rate to the output rate; the queue
//  depth of four sets how long req_tready stays high under rsp stalls.
//  Synchronous active-high reset returns phase and residual bits to zero.
// ---------------------------------------------------------------------------
module six_bit_symbol_packer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data
   input  logic       req_tuser,   // [0] mode
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] value
   output logic       rsp_tuser,   // [0] error
   output logic       rsp_tlast
);
   import sbsp_pkg::*;

   logic         in_vld_ff, in_vld_in;
   item_type     in_item_ff;
   logic         req_acc;
   logic         fire;
   core_out_type core_res;

   result_type   queue_ff [4];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [1:0]   push_n;
   logic         pop;

   // input register
   assign fire       = in_vld_ff && (cnt_ff <= 3'd2);
   assign req_tready = !in_vld_ff || fire;
   assign req_acc    = req_tvalid && req_tready;
   assign in_vld_in  = req_acc || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_item_ff <= '{mode: req_tuser, data: req_tdata, last: req_tlast};
      end
   end

   sbsp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (core_res)
   );

   // result queue
   assign push_n    = fire ? core_res.cnt : 2'd0;
   assign pop       = rsp_tvalid && rsp_tready;
   assign wr_ptr_in = wr_ptr_ff + push_n;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign cnt_in    = cnt_ff + {1'b0, push_n} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         cnt_ff    <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= core_res.res[0];
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= core_res.res[1];
      end
   end

   // result port
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff].value;
   assign rsp_tuser  = queue_ff[rd_ptr_ff].error;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].final_res;

   // queue never overfills
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result queue over capacity");

   // occupancy tracks pointers
   a_cnt_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[1:0] == (wr_ptr_ff - rd_ptr_ff)))
      else $error("queue count and pointers disagree");

   // a non-last encode item gives at most one result
   a_enc_one: assert property (@(posedge clock) disable iff (reset)
      (fire && in_item_ff.mode == MODE_ENCODE && !in_item_ff.last)
         |-> (core_res.cnt <= 2'd1))
      else $error("encode produced too many results");

   // an empty input register always takes a transaction
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_tready)
      else $error("input register empty but not ready");

endmodule

/* hdl/sbsp_core.sv */
// ---------------------------------------------------------------------------
// sbsp_core: pack/unpack datapath with phase and residual state
// Turns one registered item into up to two results combinationally and
// advances the group phase, the held-over bits and the pending error.
// ---------------------------------------------------------------------------
module sbsp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,    // item consumed this cycle
   input  sbsp_pkg::item_type   item,
   output sbsp_pkg::core_out_type result
);
   import sbsp_pkg::*;

   phase_type  phase_ff,  phase_in;
   logic [5:0] resid_ff,  resid_in;
   logic       errp_ff,   errp_in;

   logic [6:0] lookup;
   logic       unk;
   logic [5:0] idx;
   logic [5:0] id0, id1;
   logic [1:0] dcnt;
   logic [8:0] dch0, dch1;
   logic [1:0] n;

   assign lookup = char_to_index(item.data);
   assign unk    = !lookup[6];
   assign idx    = lookup[6] ? lookup[5:0] : 6'd0;
   assign dch0   = index_to_char(id0);
   assign dch1   = index_to_char(id1);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_0;
         resid_ff <= 6'd0;
         errp_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         resid_ff <= resid_in;
         errp_ff  <= errp_in;
      end
   end

   // result formation and next state
   always_comb begin
      phase_in = phase_ff;
      resid_in = resid_ff;
      errp_in  = errp_ff;
      id0      = 6'd0;
      id1      = 6'd0;
      dcnt     = 2'd1;
      n        = 2'd0;
      result   = '0;

      if (item.mode == MODE_ENCODE) begin
         result.res[0].error = unk | errp_ff;
         case (phase_ff)
            PH_0: begin
               result.res[0].value = {idx, 2'b00};
               n        = item.last ? 2'd1 : 2'd0;
               resid_in = idx;
               phase_in = PH_1;
            end
            PH_1: begin
               result.res[0].value = {resid_ff, idx[5:4]};
               result.res[1].value = {idx[3:0], 4'h0};
               n        = item.last ? 2'd2 : 2'd1;
               resid_in = {2'b00, idx[3:0]};
               phase_in = PH_2;
            end
            PH_2: begin
               result.res[0].value = {resid_ff[3:0], idx[5:2]};
               result.res[1].value = {idx[1:0], 6'd0};
               n        = item.last ? 2'd2 : 2'd1;
               resid_in = {4'h0, idx[1:0]};
               phase_in = PH_3;
            end
            default: begin
               result.res[0].value = {resid_ff[1:0], idx};
               n        = 2'd1;
               resid_in = 6'd0;
               phase_in = PH_0;
            end
         endcase
         // an unknown character with no result waits for the next one
         errp_in = (n == 2'd0) ? (errp_ff | unk) : 1'b0;
      end else begin
         case (phase_ff)
            PH_1: begin
               id0      = {resid_ff[1:0], item.data[7:4]};
               resid_in = {2'b00, item.data[3:0]};
               phase_in = PH_2;
            end
            PH_2: begin
               id0      = {resid_ff[3:0], item.data[7:6]};
               id1      = item.data[5:0];
               dcnt     = 2'd2;
               resid_in = 6'd0;
               phase_in = PH_0;
            end
            default: begin
               id0      = item.data[7:2];
               resid_in = {4'h0, item.data[1:0]};
               phase_in = PH_1;
            end
         endcase
         // drop a trailing null symbol on the last byte
         n = dcnt;
         if (item.last && ((dcnt == 2'd2) ? (id1 == 6'd0) : (id0 == 6'd0))) begin
            n = dcnt - 2'd1;
         end
         result.res[0].value = dch0[7:0];
         result.res[0].error = !dch0[8] | errp_ff;
         result.res[1].value = dch1[7:0];
         result.res[1].error = !dch1[8];
         if (n != 2'd0) begin
            errp_in = 1'b0;
         end
      end

      // final flag on the last emitted result
      if (item.last) begin
         result.res[0].final_res = (n == 2'd1);
         result.res[1].final_res = (n == 2'd2);
         phase_in = PH_0;
         resid_in = 6'd0;
         errp_in  = 1'b0;
      end
      result.cnt = n;
   end

endmodule
